@@ hw/rtl/tcbf_pkg.sv @@
`default_nettype none
// ============================================================================
// tcbf_pkg
// Shared constants and types of the tile canvas best-fit unit.
// ============================================================================
package tcbf_pkg;

    // default build parameters
    localparam int DEF_MAX_TILES = 16;
    localparam int DEF_DIM_BITS  = 14;

    // fixed field widths
    localparam int IN_W   = 14;
    localparam int MT_W   = 5;
    localparam int EDGE_W = 10;

    // register reset values
    localparam logic [MT_W-1:0]   RST_MAX_TILES = 5'd4;
    localparam logic [EDGE_W-1:0] RST_TILE_EDGE = 10'd560;

    // flags of the shared multiply unit, product against a reference
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

endpackage : tcbf_pkg
`default_nettype wire

@@ hw/rtl/tcbf_mul_cmp.sv @@
`default_nettype none
// ============================================================================
// tcbf_mul_cmp
// Shared multiplier of the walk with a magnitude compare of the product
// against a reference word.
// ============================================================================
module tcbf_mul_cmp
    import tcbf_pkg::*;
#(
    parameter int MUL_W = IN_W + 1
) (
    input  logic [MUL_W-1:0]   i_a,
    input  logic [MUL_W-1:0]   i_b,
    input  logic [2*MUL_W-1:0] i_ref,
    output logic [2*MUL_W-1:0] o_prod,
    output t_cmp               o_cmp
);

    assign o_prod    = i_a * i_b;
    assign o_cmp.gt  = o_prod > i_ref;
    assign o_cmp.eq  = o_prod == i_ref;

endmodule : tcbf_mul_cmp
`default_nettype wire

@@ hw/rtl/tile_canvas_best_fit_unit.sv @@
`default_nettype none
// ============================================================================
// tile_canvas_best_fit_unit
// Picks the tile-grid canvas that best fits one source image size.
// ============================================================================
// One image size goes in, one canvas size comes out. A sequencer walks tile
// counts t from max_tiles down to 1 and, for each t, factors f from 1 to t,
// all on a single shared multiplier. In S_TEST the cofactor steps down while
// f times it exceeds t; each divisor pair found then passes through S_CH,
// S_CW, S_LEFT, S_RIGHT, S_AREA, S_CROSS_A, S_CROSS_B and S_DECIDE to size the
// canvas and compare its scale by cross products. s_axis_tready is high only
// while the walk is idle; the result sits in an output register, so the next
// image is taken while a result still waits.
// ============================================================================
module tile_canvas_best_fit_unit
    import tcbf_pkg::*;
#(
    parameter int MAX_TILES = DEF_MAX_TILES,
    parameter int DIM_BITS  = DEF_DIM_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // image size in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // image_height[13:0], image_width[27:14], zero
    // canvas out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // canvas_height[13:0], canvas_width[27:14], zero
    output logic             m_axis_tuser   // is_upscale
);

    localparam int TC_W   = $clog2(MAX_TILES + 1);
    localparam int SIDE_W = TC_W + EDGE_W;
    localparam int MUL_W  = (SIDE_W > IN_W) ? SIDE_W : IN_W;
    localparam int P_W    = 2 * MUL_W;
    localparam int AREA_W = 2 * SIDE_W;
    localparam logic [31:0] DIM_MAX = 32'((64'd1 << DIM_BITS) - 64'd1);

    typedef enum logic [1:0] {
        REG_MAX_TILES = 2'd0,
        REG_TILE_EDGE = 2'd1,
        REG_GROW      = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TEST,
        S_CH,
        S_CW,
        S_LEFT,
        S_RIGHT,
        S_AREA,
        S_CROSS_A,
        S_CROSS_B,
        S_DECIDE,
        S_DONE
    } t_state;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MT_W-1:0]   r_max_tiles;
    logic [EDGE_W-1:0] r_tile_edge;
    logic              r_grow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tiles <= RST_MAX_TILES;
            r_tile_edge <= RST_TILE_EDGE;
            r_grow      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_MAX_TILES: r_max_tiles <= pwdata[MT_W-1:0];
                REG_TILE_EDGE: r_tile_edge <= pwdata[EDGE_W-1:0];
                REG_GROW:      r_grow      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_MAX_TILES: prdata = 32'(r_max_tiles);
            REG_TILE_EDGE: prdata = 32'(r_tile_edge);
            REG_GROW:      prdata = 32'(r_grow);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // walk registers
    // ------------------------------------------------------------------
    t_state            r_state;
    logic [IN_W-1:0]   r_ih;
    logic [IN_W-1:0]   r_iw;
    logic [EDGE_W-1:0] r_edge;
    logic [TC_W-1:0]   r_mt;
    logic [TC_W-1:0]   r_t;
    logic [TC_W-1:0]   r_f;
    logic [TC_W-1:0]   r_g;
    logic [SIDE_W-1:0] r_ch;
    logic [SIDE_W-1:0] r_cw;
    logic [P_W-1:0]    r_left;
    logic [SIDE_W-1:0] r_num;
    logic [IN_W-1:0]   r_den;
    logic [AREA_W-1:0] r_area;
    t_cmp              r_cross;
    logic [SIDE_W-1:0] r_best_num;
    logic [IN_W-1:0]   r_best_den;
    logic [AREA_W-1:0] r_best_area;
    logic [SIDE_W-1:0] r_best_h;
    logic [SIDE_W-1:0] r_best_w;
    logic              r_have;
    logic              r_ovalid;
    logic [IN_W-1:0]   r_out_h;
    logic [IN_W-1:0]   r_out_w;
    logic              r_out_up;

    // clamped values taken at accept
    logic [IN_W-1:0]   w_ih;
    logic [IN_W-1:0]   w_iw;
    logic [TC_W-1:0]   w_mt;
    logic [EDGE_W-1:0] w_edge;

    always_comb begin
        w_ih   = (s_axis_tdata[IN_W-1:0] == '0) ? IN_W'(1) : s_axis_tdata[IN_W-1:0];
        w_iw   = (s_axis_tdata[2*IN_W-1:IN_W] == '0) ? IN_W'(1)
                                                     : s_axis_tdata[2*IN_W-1:IN_W];
        w_edge = (r_tile_edge == '0) ? EDGE_W'(1) : r_tile_edge;
        if (r_max_tiles == '0) begin
            w_mt = TC_W'(1);
        end else if (32'(r_max_tiles) > MAX_TILES) begin
            w_mt = TC_W'(MAX_TILES);
        end else begin
            w_mt = TC_W'(r_max_tiles);
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier operand select
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] w_a;
    logic [MUL_W-1:0] w_b;
    logic [P_W-1:0]   w_ref;
    logic [P_W-1:0]   w_prod;
    t_cmp             w_cmp;

    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_ref = r_left;
        unique case (r_state)
            S_TEST: begin
                w_a   = MUL_W'(r_f);
                w_b   = MUL_W'(r_g);
                w_ref = P_W'(r_t);
            end
            S_CH: begin
                w_a = MUL_W'(r_f);
                w_b = MUL_W'(r_edge);
            end
            S_CW: begin
                w_a = MUL_W'(r_g);
                w_b = MUL_W'(r_edge);
            end
            S_LEFT: begin
                w_a = MUL_W'(r_ch);
                w_b = MUL_W'(r_iw);
            end
            S_RIGHT: begin
                w_a = MUL_W'(r_cw);
                w_b = MUL_W'(r_ih);
            end
            S_AREA: begin
                w_a = MUL_W'(r_ch);
                w_b = MUL_W'(r_cw);
            end
            S_CROSS_A: begin
                w_a = MUL_W'(r_num);
                w_b = MUL_W'(r_best_den);
            end
            S_CROSS_B: begin
                w_a = MUL_W'(r_best_num);
                w_b = MUL_W'(r_den);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    tcbf_mul_cmp #(
        .MUL_W (MUL_W)
    ) u_mul (
        .i_a    (w_a),
        .i_b    (w_b),
        .i_ref  (w_ref),
        .o_prod (w_prod),
        .o_cmp  (w_cmp)
    );

    // ------------------------------------------------------------------
    // next factor / tile count
    // ------------------------------------------------------------------
    logic [TC_W-1:0] n_t;
    logic [TC_W-1:0] n_f;
    logic [TC_W-1:0] n_g;
    t_state          n_adv_state;

    always_comb begin
        n_t         = r_t;
        n_f         = r_f + TC_W'(1);
        n_g         = r_g;
        n_adv_state = S_TEST;
        if (r_f == r_t) begin
            if (r_t == TC_W'(1)) begin
                n_adv_state = S_DONE;
            end else begin
                n_t = r_t - TC_W'(1);
                n_f = TC_W'(1);
                n_g = r_t - TC_W'(1);
            end
        end
    end

    // take decision of the current canvas
    logic w_cur_up;
    logic w_best_up;
    logic w_take;
    logic w_gt;
    logic w_lt;

    always_comb begin
        w_cur_up  = r_num >= SIDE_W'(r_den);
        w_best_up = r_best_num >= SIDE_W'(r_best_den);
        // cross product A is the current scale side, B the stored one
        w_lt      = r_cross.gt;
        w_gt      = !r_cross.gt && !r_cross.eq;
        priority if (!r_have) begin
            w_take = 1'b1;
        end else if (w_cur_up && !w_best_up) begin
            w_take = 1'b1;
        end else if (!w_cur_up && w_best_up) begin
            w_take = 1'b0;
        end else if (w_cur_up) begin
            if (r_cross.eq) begin
                w_take = r_area < r_best_area;
            end else begin
                w_take = r_grow ? w_gt : w_lt;
            end
        end else begin
            w_take = w_gt;
        end
    end

    // output saturation
    logic [31:0] w_sat_h;
    logic [31:0] w_sat_w;

    assign w_sat_h = (32'(r_best_h) > DIM_MAX) ? DIM_MAX : 32'(r_best_h);
    assign w_sat_w = (32'(r_best_w) > DIM_MAX) ? DIM_MAX : 32'(r_best_w);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_have     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_t        <= '0;
            r_f        <= '0;
            r_g        <= '0;
            r_best_num <= '0;
            r_best_den <= IN_W'(1);
        end else begin
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ih        <= w_ih;
                        r_iw        <= w_iw;
                        r_edge      <= w_edge;
                        r_mt        <= w_mt;
                        r_t         <= w_mt;
                        r_f         <= TC_W'(1);
                        r_g         <= w_mt;
                        r_have      <= 1'b0;
                        r_best_num  <= '0;
                        r_best_den  <= IN_W'(1);
                        r_best_area <= '0;
                        r_best_h    <= '0;
                        r_best_w    <= '0;
                        r_state     <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (w_cmp.gt) begin
                        r_g <= r_g - TC_W'(1);
                    end else if (w_cmp.eq) begin
                        r_state <= S_CH;
                    end else begin
                        r_t     <= n_t;
                        r_f     <= n_f;
                        r_g     <= n_g;
                        r_state <= n_adv_state;
                    end
                end
                S_CH: begin
                    r_ch    <= w_prod[SIDE_W-1:0];
                    r_state <= S_CW;
                end
                S_CW: begin
                    r_cw    <= w_prod[SIDE_W-1:0];
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    r_left  <= w_prod;
                    r_state <= S_RIGHT;
                end
                S_RIGHT: begin
                    // height ratio is the smaller one when ch*iw <= cw*ih
                    if (w_cmp.gt || w_cmp.eq) begin
                        r_num <= r_ch;
                        r_den <= r_ih;
                    end else begin
                        r_num <= r_cw;
                        r_den <= r_iw;
                    end
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_area  <= w_prod[AREA_W-1:0];
                    r_state <= S_CROSS_A;
                end
                S_CROSS_A: begin
                    r_left  <= w_prod;
                    r_state <= S_CROSS_B;
                end
                S_CROSS_B: begin
                    r_cross <= w_cmp;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_take) begin
                        r_best_num  <= r_num;
                        r_best_den  <= r_den;
                        r_best_area <= r_area;
                        r_best_h    <= r_ch;
                        r_best_w    <= r_cw;
                        r_have      <= 1'b1;
                    end
                    r_t     <= n_t;
                    r_f     <= n_f;
                    r_g     <= n_g;
                    r_state <= n_adv_state;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_out_h  <= w_sat_h[IN_W-1:0];
                        r_out_w  <= w_sat_w[IN_W-1:0];
                        r_out_up <= w_best_up;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(32 - 2 * IN_W){1'b0}}, r_out_w, r_out_h};
    assign m_axis_tuser  = r_out_up;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_cofactor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |-> (r_g != '0))
        else $error("cofactor reached zero during factor test");

    a_factor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |-> (r_f != '0 && r_f <= r_t))
        else $error("factor outside 1..tile count");

    a_tile_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_t != '0 && r_t <= r_mt))
        else $error("tile count outside 1..max tiles");

    a_done_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_have)
        else $error("walk ended without a canvas");

    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_TEST && !r_have))
        else $error("accepted transaction did not start a fresh walk");

endmodule : tile_canvas_best_fit_unit
`default_nettype wire

@@ bench/tcbf_bench_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tcbf_bench_pkg
// Register map of the tile canvas best-fit unit as seen by the bench.
// ============================================================================
// Byte addresses on the apb configuration port, shared by the stimulus side
// that writes them and the checker that tracks them.
// ============================================================================
package tcbf_bench_pkg;

    localparam logic [3:0] ADDR_MAX_TILES   = 4'h0;
    localparam logic [3:0] ADDR_TILE_EDGE   = 4'h4;
    localparam logic [3:0] ADDR_GROW_TO_MAX = 4'h8;

endpackage : tcbf_bench_pkg

@@ bench/tile_canvas_best_fit_unit_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tile_canvas_best_fit_unit_checker
// Predicts and checks every canvas chosen by the tile canvas best-fit unit.
// ============================================================================
// Watches the apb port to keep its own copy of the three registers, computes
// the best-fit canvas for each accepted image size and compares each accepted
// canvas transaction, field by field, with the oldest prediction. Mismatch and
// outstanding counts go back to the bench top as registered outputs.
// ============================================================================
module tile_canvas_best_fit_unit_checker
    import tcbf_pkg::*;
    import tcbf_bench_pkg::*;
#(
    parameter int MAX_TILES = DEF_MAX_TILES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // image_height[13:0], image_width[27:14], zero
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,  // canvas_height[13:0], canvas_width[27:14], zero
    input  wire logic        m_axis_tuser,  // is_upscale
    output int               o_mismatches,
    output int               o_pending
);

    typedef struct packed {
        logic [13:0] height;
        logic [13:0] width;
        logic        upscale;
    } t_canvas;

    logic [MT_W-1:0]   cfg_max_tiles = RST_MAX_TILES;
    logic [EDGE_W-1:0] cfg_tile_edge = RST_TILE_EDGE;
    logic              cfg_grow      = 1'b0;

    t_canvas canvas_due_q[$];
    int      mismatch_count = 0;

    // exhaustive walk over all tile grids, scales compared as exact fractions
    function automatic t_canvas best_canvas(input logic [13:0] img_h,
                                            input logic [13:0] img_w);
        logic [31:0] ih, iw, unit_px, ch, cw, num, den, area;
        logic [31:0] b_num, b_den, b_area, b_h, b_w, lhs, rhs;
        logic        have, take, cand_up, best_up;
        int          tiles, t, f;
        t_canvas     res;
        ih      = (img_h == 0) ? 32'd1 : 32'(img_h);
        iw      = (img_w == 0) ? 32'd1 : 32'(img_w);
        unit_px = (cfg_tile_edge == 0) ? 32'd1 : 32'(cfg_tile_edge);
        tiles   = (cfg_max_tiles == 0) ? 1 : int'(cfg_max_tiles);
        if (tiles > MAX_TILES) tiles = MAX_TILES;
        have   = 1'b0;
        b_num  = 0;
        b_den  = 1;
        b_area = 0;
        b_h    = 0;
        b_w    = 0;
        for (t = tiles; t > 0; t--) begin
            for (f = 1; f <= t; f++) begin
                if (t % f == 0) begin
                    ch = 32'(f) * unit_px;
                    cw = 32'(t / f) * unit_px;
                    // the tighter side sets the aspect-preserving scale
                    if (ch * iw <= cw * ih) begin
                        num = ch;
                        den = ih;
                    end else begin
                        num = cw;
                        den = iw;
                    end
                    area    = ch * cw;
                    cand_up = num >= den;
                    best_up = b_num >= b_den;
                    lhs     = num * b_den;
                    rhs     = b_num * den;
                    if (!have) take = 1'b1;
                    else if (cand_up != best_up) take = cand_up;
                    else if (!cand_up) take = lhs > rhs;
                    else if (lhs == rhs) take = area < b_area;
                    else if (cfg_grow) take = lhs > rhs;
                    else take = lhs < rhs;
                    if (take) begin
                        b_num  = num;
                        b_den  = den;
                        b_area = area;
                        b_h    = ch;
                        b_w    = cw;
                        have   = 1'b1;
                    end
                end
            end
        end
        res.height  = (b_h > 32'h3fff) ? 14'h3fff : b_h[13:0];
        res.width   = (b_w > 32'h3fff) ? 14'h3fff : b_w[13:0];
        res.upscale = b_num >= b_den;
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_canvas seen;
        t_canvas want;
        if (!i_rst_n) begin
            cfg_max_tiles = RST_MAX_TILES;
            cfg_tile_edge = RST_TILE_EDGE;
            cfg_grow      = 1'b0;
            canvas_due_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = '{m_axis_tdata[13:0], m_axis_tdata[27:14], m_axis_tuser};
                if (canvas_due_q.size() == 0) begin
                    $display("%0t: canvas transaction with none expected: h=%0d w=%0d up=%0b",
                             $time, seen.height, seen.width, seen.upscale);
                    mismatch_count++;
                end else begin
                    want = canvas_due_q.pop_front();
                    if (seen !== want) begin
                        $display({"%0t: canvas mismatch: expected h=%0d w=%0d up=%0b,",
                                  " got h=%0d w=%0d up=%0b"},
                                 $time, want.height, want.width, want.upscale,
                                 seen.height, seen.width, seen.upscale);
                        mismatch_count++;
                    end
                end
            end
            // prediction uses the settings in force before this edge
            if (s_axis_tvalid && s_axis_tready)
                canvas_due_q.insert(canvas_due_q.size(),
                                    best_canvas(s_axis_tdata[13:0], s_axis_tdata[27:14]));
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_MAX_TILES:   cfg_max_tiles = pwdata[MT_W-1:0];
                    ADDR_TILE_EDGE:   cfg_tile_edge = pwdata[EDGE_W-1:0];
                    ADDR_GROW_TO_MAX: cfg_grow      = pwdata[0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= canvas_due_q.size();
    end

endmodule : tile_canvas_best_fit_unit_checker

@@ bench/tile_canvas_best_fit_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tile_canvas_best_fit_unit_tb
// Stimulus and verdict for the tile canvas best-fit unit.
// ============================================================================
// A short directed set covers extreme image sides, exact fits, ties and the
// register corners (zero and oversized tile counts, zero and full tile edge,
// both selection modes). Eight random phases follow under fresh register
// settings, taking four handshake pressure modes in turn. The checker
// instance does all prediction and comparison; this module drives and reports.
// ============================================================================
module tile_canvas_best_fit_unit_tb;
    import tcbf_pkg::*;
    import tcbf_bench_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_CYCLES  = 32;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // image_height[13:0], image_width[27:14], zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // canvas_height[13:0], canvas_width[27:14], zero
    logic        m_axis_tuser;        // is_upscale

    int mismatches;
    int canvases_due;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cur_tiles      = RST_MAX_TILES;
    int cur_edge       = RST_TILE_EDGE;

    tile_canvas_best_fit_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tile_canvas_best_fit_unit_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (canvases_due)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 88;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 88;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 37;
                recv_stall_pct = 37;
            end
        endcase
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [4:0] tiles, input logic [9:0] edge_px,
                                input logic grow);
        write_reg(ADDR_MAX_TILES, 32'(tiles));
        write_reg(ADDR_TILE_EDGE, 32'(edge_px));
        write_reg(ADDR_GROW_TO_MAX, 32'(grow));
        cur_tiles = tiles;
        cur_edge  = edge_px;
    endtask

    // valid stays high across back-to-back transactions, dropped only for a gap
    task automatic send_size(input logic [13:0] img_h, input logic [13:0] img_w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, img_w, img_h};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic end_batch();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (canvases_due != 0) @(posedge i_clk);
    endtask

    // mix of full-range sides, small sides and sides near a tile multiple
    function automatic logic [13:0] pick_side();
        int unit_px;
        int span;
        int v;
        unit_px = (cur_edge == 0) ? 1 : cur_edge;
        span    = (cur_tiles == 0) ? 1 : (cur_tiles > DEF_MAX_TILES) ? DEF_MAX_TILES : cur_tiles;
        case ($urandom_range(3))
            0, 1: v = $urandom_range(16383);
            2: v = $urandom_range(1, 2 * unit_px);
            default: v = $urandom_range(1, span) * unit_px + $urandom_range(2) - 1;
        endcase
        return (v > 16383) ? 14'h3fff : 14'(v);
    endfunction

    initial begin : stimulus
        int p;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: four tiles of 560
        send_size(14'd0, 14'd0);
        send_size(14'd16383, 14'd16383);
        send_size(14'd1, 14'd16383);
        send_size(14'd16383, 14'd1);
        send_size(14'd560, 14'd560);
        send_size(14'd1120, 14'd1120);
        send_size(14'd560, 14'd2240);
        send_size(14'd1121, 14'd1121);
        send_size(14'd300, 14'd1000);
        end_batch();

        // zero tile count and zero edge collapse to a single one-pixel tile
        write_config(5'd0, 10'd0, 1'b1);
        send_size(14'd1, 14'd1);
        send_size(14'd2, 14'd3);
        send_size(14'd0, 14'd16383);
        end_batch();

        // oversized tile count saturates, largest edge
        write_config(5'd31, 10'd1023, 1'b1);
        send_size(14'd1, 14'd1);
        send_size(14'd16383, 14'd16383);
        send_size(14'd1023, 14'd4092);
        send_size(14'd5000, 14'd3000);
        end_batch();

        write_config(5'd16, 10'd1, 1'b0);
        send_size(14'd0, 14'd0);
        send_size(14'd1, 14'd16);
        send_size(14'd16, 14'd16);
        send_size(14'd4, 14'd4);
        end_batch();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: write_config(5'd16, 10'd1023, 1'b0);
                1: write_config(5'd1, 10'd1, 1'b1);
                2: write_config(5'd31, 10'd560, 1'b1);
                3: write_config(5'd0, 10'd1023, 1'b0);
                default: write_config(5'($urandom_range(1, 8)), 10'($urandom_range(1023)),
                                      1'($urandom_range(1)));
            endcase
            set_idle(t_idle_mode'(p % 4));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_size(pick_side(), pick_side());
            end_batch();
        end

        set_idle(IDLE_NONE);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && canvases_due == 0) begin
            $display("tile_canvas_best_fit_unit_tb: done, clean");
        end else begin
            $display("tile_canvas_best_fit_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(30_000_000);
        $display("tile_canvas_best_fit_unit_tb: done, errors");
        $finish;
    end

endmodule : tile_canvas_best_fit_unit_tb
